### design/ccdsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccdsb_pkg;

  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned Sixty       = 60;
  localparam logic [5:0]  LastUnit    = 6'd59;
  localparam logic [4:0]  LastHour    = 5'd23;

  localparam logic [15:0] LongPressReset  = 16'd2000;
  localparam logic [15:0] RepeatReset     = 16'd200;
  localparam logic [15:0] ResetHoldReset  = 16'd5000;
  localparam logic [9:0]  TicksPerSecReset = 10'd1000;
  localparam logic [9:0]  BlinkHalfReset  = 10'd500;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgLongPress = 3'd0,
    CfgRepeat    = 3'd1,
    CfgResetHold = 3'd2,
    CfgTicksSec  = 3'd3,
    CfgBlinkHalf = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic hour_pressed;
    logic minute_pressed;
    logic second_pressed;
    logic pause_pressed;
    logic mode_pressed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hours_tens;
    logic [3:0] hours_units;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_units;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_units;
    logic       display_on;
    logic       in_timer_mode;
    logic       clock_halted;
    logic       timer_halted;
    logic       timer_expired;
  } out_item_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
    logic [15:0] reset_hold_ms;
    logic [9:0]  ticks_per_second;
    logic [9:0]  blink_half_ms;
  } cfg_t;

  // Key events decoded for one tick.
  typedef struct packed {
    logic bump_hour;
    logic bump_minute;
    logic bump_second;
    logic pause_toggle;
    logic pause_zero;
    logic mode_toggle;
  } key_evt_t;

  // Time and flags after one tick.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       display_on;
    logic       in_timer_mode;
    logic       clock_halted;
    logic       timer_halted;
    logic       timer_expired;
  } time_view_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } digits_t;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [9:0] sat10(input logic [9:0] v);
    return (v == 10'h3FF) ? v : v + 10'd1;
  endfunction

  // Split a value below sixty into two decimal digits.
  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t    r;
    logic [5:0] base;
    if (v >= 6'd50) begin
      r.tens = 3'd5; base = 6'd50;
    end else if (v >= 6'd40) begin
      r.tens = 3'd4; base = 6'd40;
    end else if (v >= 6'd30) begin
      r.tens = 3'd3; base = 6'd30;
    end else if (v >= 6'd20) begin
      r.tens = 3'd2; base = 6'd20;
    end else if (v >= 6'd10) begin
      r.tens = 3'd1; base = 6'd10;
    end else begin
      r.tens = 3'd0; base = 6'd0;
    end
    r.units = 4'(v - base);
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ccdsb_keys.sv
`timescale 1ns / 1ps
`default_nettype none

module ccdsb_keys import ccdsb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output key_evt_t      evt_o
);

  logic [2:0]  set_holding_q, set_holding_d;
  logic [15:0] set_hold_q [3];
  logic [15:0] set_hold_d [3];
  logic [15:0] set_rep_q [3];
  logic [15:0] set_rep_d [3];
  logic        pause_holding_q, pause_holding_d;
  logic [15:0] pause_hold_q, pause_hold_d;
  logic        mode_last_q;
  logic [2:0]  set_key;
  logic [2:0]  bump;
  logic        pause_toggle;
  logic        pause_zero;

  assign set_key = {item_i.second_pressed, item_i.minute_pressed, item_i.hour_pressed};

  // Set keys: short press adds one on release, a long hold auto-repeats.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      set_holding_d[k] = set_holding_q[k];
      set_hold_d[k]    = set_holding_q[k] ? sat16(set_hold_q[k]) : set_hold_q[k];
      set_rep_d[k]     = set_holding_q[k] ? sat16(set_rep_q[k]) : set_rep_q[k];
      bump[k]          = 1'b0;
      if (set_key[k]) begin
        if (!set_holding_q[k]) begin
          set_holding_d[k] = 1'b1;
          set_hold_d[k]    = '0;
          set_rep_d[k]     = '0;
        end else if (set_hold_d[k] >= cfg_i.long_press_ms &&
                     set_rep_d[k] >= cfg_i.repeat_ms) begin
          bump[k]      = 1'b1;
          set_rep_d[k] = '0;
        end
      end else if (set_holding_q[k]) begin
        bump[k]          = set_hold_d[k] < cfg_i.long_press_ms;
        set_holding_d[k] = 1'b0;
      end
    end
  end

  // Pause key: short release toggles, a long hold zeroes and ends the hold.
  always_comb begin
    pause_holding_d = pause_holding_q;
    pause_hold_d    = pause_holding_q ? sat16(pause_hold_q) : pause_hold_q;
    pause_toggle    = 1'b0;
    pause_zero      = 1'b0;
    if (item_i.pause_pressed) begin
      if (!pause_holding_q) begin
        pause_holding_d = 1'b1;
        pause_hold_d    = '0;
      end else if (pause_hold_d >= cfg_i.reset_hold_ms) begin
        pause_zero      = 1'b1;
        pause_holding_d = 1'b0;
      end
    end else if (pause_holding_q) begin
      pause_toggle    = pause_hold_d < cfg_i.reset_hold_ms;
      pause_holding_d = 1'b0;
    end
  end

  assign evt_o.bump_hour    = bump[0];
  assign evt_o.bump_minute  = bump[1];
  assign evt_o.bump_second  = bump[2];
  assign evt_o.pause_toggle = pause_toggle;
  assign evt_o.pause_zero   = pause_zero;
  assign evt_o.mode_toggle  = !mode_last_q && item_i.mode_pressed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_holding_q   <= '0;
      pause_holding_q <= 1'b0;
      pause_hold_q    <= '0;
      mode_last_q     <= 1'b1;
      for (int k = 0; k < 3; k++) begin
        set_hold_q[k] <= '0;
        set_rep_q[k]  <= '0;
      end
    end else if (en_i) begin
      set_holding_q   <= set_holding_d;
      pause_holding_q <= pause_holding_d;
      pause_hold_q    <= pause_hold_d;
      mode_last_q     <= item_i.mode_pressed;
      for (int k = 0; k < 3; k++) begin
        set_hold_q[k] <= set_hold_d[k];
        set_rep_q[k]  <= set_rep_d[k];
      end
    end
  end

endmodule

`default_nettype wire

### design/ccdsb_time.sv
`timescale 1ns / 1ps
`default_nettype none

module ccdsb_time import ccdsb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire key_evt_t evt_i,
  input  wire cfg_t     cfg_i,
  output time_view_t    view_o
);

  logic [4:0] clk_h_q, clk_h_d, cd_h_q, cd_h_d;
  logic [5:0] clk_m_q, clk_m_d, cd_m_q, cd_m_d;
  logic [5:0] clk_s_q, clk_s_d, cd_s_q, cd_s_d;
  logic [9:0] tick_q, tick_d, blink_q, blink_d;
  logic       mode_q, mode_d;
  logic       clk_pause_q, clk_pause_d, cd_pause_q, cd_pause_d;
  logic       expired_q, expired_d;
  logic       phase_q, phase_d;
  logic       sec_step;
  logic       cd_zero;

  assign cd_zero = (cd_h_q == '0) && (cd_m_q == '0) && (cd_s_q == '0);

  always_comb begin
    clk_h_d = clk_h_q; clk_m_d = clk_m_q; clk_s_d = clk_s_q;
    cd_h_d  = cd_h_q;  cd_m_d  = cd_m_q;  cd_s_d  = cd_s_q;
    clk_pause_d = clk_pause_q;
    cd_pause_d  = cd_pause_q;
    expired_d   = expired_q;
    mode_d      = mode_q;
    phase_d     = phase_q;

    // Second step.
    tick_d   = sat10(tick_q);
    sec_step = tick_d >= cfg_i.ticks_per_second;
    if (sec_step) begin
      tick_d = '0;
      if (!clk_pause_q) begin
        if (clk_s_q == LastUnit) begin
          clk_s_d = '0;
          if (clk_m_q == LastUnit) begin
            clk_m_d = '0;
            clk_h_d = (clk_h_q == LastHour) ? '0 : clk_h_q + 5'd1;
          end else begin
            clk_m_d = clk_m_q + 6'd1;
          end
        end else begin
          clk_s_d = clk_s_q + 6'd1;
        end
      end
      if (mode_q && !cd_pause_q) begin
        if (cd_zero) begin
          expired_d = 1'b1;
        end else begin
          expired_d = 1'b0;
          if (cd_s_q != '0) begin
            cd_s_d = cd_s_q - 6'd1;
          end else begin
            cd_s_d = LastUnit;
            if (cd_m_q != '0) begin
              cd_m_d = cd_m_q - 6'd1;
            end else begin
              cd_m_d = LastUnit;
              if (cd_h_q != '0) cd_h_d = cd_h_q - 5'd1;
            end
          end
        end
      end
    end

    // Set keys act on the mode in force before this tick's toggle.
    if (mode_q) begin
      if (evt_i.bump_hour)   cd_h_d = (cd_h_d == LastHour) ? '0 : cd_h_d + 5'd1;
      if (evt_i.bump_minute) cd_m_d = (cd_m_d == LastUnit) ? '0 : cd_m_d + 6'd1;
      if (evt_i.bump_second) cd_s_d = (cd_s_d == LastUnit) ? '0 : cd_s_d + 6'd1;
    end else begin
      if (evt_i.bump_hour)   clk_h_d = (clk_h_d == LastHour) ? '0 : clk_h_d + 5'd1;
      if (evt_i.bump_minute) clk_m_d = (clk_m_d == LastUnit) ? '0 : clk_m_d + 6'd1;
      if (evt_i.bump_second) clk_s_d = (clk_s_d == LastUnit) ? '0 : clk_s_d + 6'd1;
    end

    // Pause key.
    if (evt_i.pause_zero) begin
      if (mode_q) begin
        cd_h_d = '0; cd_m_d = '0; cd_s_d = '0;
        cd_pause_d = 1'b1;
      end else begin
        clk_h_d = '0; clk_m_d = '0; clk_s_d = '0;
        clk_pause_d = 1'b1;
      end
    end else if (evt_i.pause_toggle) begin
      if (mode_q) cd_pause_d = !cd_pause_q;
      else        clk_pause_d = !clk_pause_q;
    end

    if (evt_i.mode_toggle) mode_d = !mode_q;

    // The blink phase flips only while an expired timer is shown; its counter always runs.
    blink_d = sat10(blink_q);
    if (mode_d && expired_d && (blink_d >= cfg_i.blink_half_ms)) begin
      phase_d = !phase_q;
      blink_d = '0;
    end
  end

  assign view_o.hours         = mode_d ? cd_h_d : clk_h_d;
  assign view_o.minutes       = mode_d ? cd_m_d : clk_m_d;
  assign view_o.seconds       = mode_d ? cd_s_d : clk_s_d;
  assign view_o.display_on    = (mode_d && expired_d) ? phase_d : 1'b1;
  assign view_o.in_timer_mode = mode_d;
  assign view_o.clock_halted  = clk_pause_d;
  assign view_o.timer_halted  = cd_pause_d;
  assign view_o.timer_expired = expired_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_h_q <= '0; clk_m_q <= '0; clk_s_q <= '0;
      cd_h_q  <= '0; cd_m_q  <= '0; cd_s_q  <= '0;
      tick_q      <= '0;
      blink_q     <= '0;
      mode_q      <= 1'b0;
      clk_pause_q <= 1'b0;
      cd_pause_q  <= 1'b0;
      expired_q   <= 1'b0;
      phase_q     <= 1'b0;
    end else if (en_i) begin
      clk_h_q <= clk_h_d; clk_m_q <= clk_m_d; clk_s_q <= clk_s_d;
      cd_h_q  <= cd_h_d;  cd_m_q  <= cd_m_d;  cd_s_q  <= cd_s_d;
      tick_q      <= tick_d;
      blink_q     <= blink_d;
      mode_q      <= mode_d;
      clk_pause_q <= clk_pause_d;
      cd_pause_q  <= cd_pause_d;
      expired_q   <= expired_d;
      phase_q     <= phase_d;
    end
  end

endmodule

`default_nettype wire

### design/clock_and_countdown_with_set_buttons_unit.sv
// The result of a tick is in the output register in the cycle after its transfer.
// Throughput: one tick per cycle; the output register is the only buffer, and a new
// tick is taken whenever that register is empty or being emptied in the same cycle.
// Reset (rst_ni, asynchronous, active low) zeroes both times and all counters,
// selects clock mode with both running, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module clock_and_countdown_with_set_buttons_unit import ccdsb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // Tick input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  cfg_t       cfg_q;
  logic       accept;
  key_evt_t   evt;
  time_view_t view;
  digits_t    h_dig, m_dig, s_dig;
  out_item_t  out_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  // Configuration registers. Indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms    <= LongPressReset;
      cfg_q.repeat_ms        <= RepeatReset;
      cfg_q.reset_hold_ms    <= ResetHoldReset;
      cfg_q.ticks_per_second <= TicksPerSecReset;
      cfg_q.blink_half_ms    <= BlinkHalfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLongPress: cfg_q.long_press_ms    <= cfg_data_i;
        CfgRepeat:    cfg_q.repeat_ms        <= cfg_data_i;
        CfgResetHold: cfg_q.reset_hold_ms    <= cfg_data_i;
        CfgTicksSec:  cfg_q.ticks_per_second <= cfg_data_i[9:0];
        CfgBlinkHalf: cfg_q.blink_half_ms    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // The input side stalls only when a finished result waits and the sink stalls too.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Button decoding: hold counters, auto-repeat and edge detection.
  ccdsb_keys u_keys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .evt_o  (evt)
  );

  // Time keeping: second step, set, pause, mode and blink, in that order.
  ccdsb_time u_time (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .evt_i  (evt),
    .cfg_i  (cfg_q),
    .view_o (view)
  );

  // Decimal digits of the time shown after this tick.
  always_comb begin
    h_dig = split_digits({1'b0, view.hours});
    m_dig = split_digits(view.minutes);
    s_dig = split_digits(view.seconds);
    out_d.hours_tens    = h_dig.tens[1:0];
    out_d.hours_units   = h_dig.units;
    out_d.minutes_tens  = m_dig.tens;
    out_d.minutes_units = m_dig.units;
    out_d.seconds_tens  = s_dig.tens;
    out_d.seconds_units = s_dig.units;
    out_d.display_on    = view.display_on;
    out_d.in_timer_mode = view.in_timer_mode;
    out_d.clock_halted  = view.clock_halted;
    out_d.timer_halted  = view.timer_halted;
    out_d.timer_expired = view.timer_expired;
  end

  // Output register: filled on every transfer in, held while the sink stalls.
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

// Testbench for the clock and countdown unit.
//
// Every transfer on the tick channel is one millisecond tick carrying five
// button levels, and it produces exactly one display transfer. The testbench
// keeps its own model of the clock, the countdown, the key hold counters and
// the blink logic. For every accepted tick it computes the display that the
// unit should show and queues it. A checker process compares every display
// transfer, field by field, with the oldest queued display.
//
// The named test tasks below run in turn from the main initial block. They
// cover the state right after reset, the lowest register settings, registers
// written as zero, the highest settings, long runs of random key gestures under
// random register settings, and back-pressure. Registers are only written once
// every queued display has come out, so the unit is idle while they change.
module testbench;
  import ccdsb_pkg::*;

  // A run ends in failure once this many cycles pass without any transfer.
  localparam int unsigned IdleLimit = 1000;

  // An index beyond the last register; a write to it must change nothing.
  localparam logic [2:0] CfgUnused = 3'd7;

  // Button patterns, hour key in the top bit, mode key in the bottom bit.
  localparam in_item_t KeyNone   = 5'b00000;
  localparam in_item_t KeyHour   = 5'b10000;
  localparam in_item_t KeyMinute = 5'b01000;
  localparam in_item_t KeySecond = 5'b00100;
  localparam in_item_t KeyPause  = 5'b00010;
  localparam in_item_t KeyMode   = 5'b00001;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = 3'd0;
  logic [15:0] cfg_data_i  = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  // The mode key starts out pressed, so it is held straight through reset.
  in_item_t    in_data_i   = KeyMode;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  always #5 clk_i = ~clk_i;

  clock_and_countdown_with_set_buttons_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Displays that accepted ticks should produce, oldest first.
  out_item_t   pending_display [$];

  int unsigned fail_count     = 0;
  int unsigned ticks_sent     = 0;
  int unsigned displays_seen  = 0;
  int unsigned settings_used  = 0;
  int unsigned idle_cycles    = 0;

  // Traffic shaping. The receiver takes a one-off hold-off request, counted in
  // cycles, the next time it is ready to stall.
  bit          gaps_on         = 1'b1;
  bit          stalls_on       = 1'b1;
  int unsigned rx_hold_request = 0;

  // ---------------------------------------------------------------------------
  // Model of the unit: register copies and state.
  // ---------------------------------------------------------------------------
  logic [15:0] long_cfg, repeat_cfg, zero_hold_cfg;
  logic [9:0]  tps_cfg, blink_cfg;

  logic [4:0]  clk_hr, cd_hr;
  logic [5:0]  clk_min, clk_sec, cd_min, cd_sec;
  logic [9:0]  sec_ticks, blink_ticks;
  logic        timer_mode, clk_paused, tmr_paused, expired, blink_lit;
  logic        set_held [3];
  logic [15:0] set_held_for [3];
  logic [15:0] set_since_rep [3];
  logic        pz_held;
  logic [15:0] pz_held_for;
  logic        mode_prev;

  function automatic void reset_model();
    long_cfg      = LongPressReset;
    repeat_cfg    = RepeatReset;
    zero_hold_cfg = ResetHoldReset;
    tps_cfg       = TicksPerSecReset;
    blink_cfg     = BlinkHalfReset;
    clk_hr = '0; clk_min = '0; clk_sec = '0;
    cd_hr  = '0; cd_min  = '0; cd_sec  = '0;
    sec_ticks = '0; blink_ticks = '0;
    timer_mode = 1'b0; clk_paused = 1'b0; tmr_paused = 1'b0;
    expired = 1'b0; blink_lit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      set_held[k] = 1'b0; set_held_for[k] = '0; set_since_rep[k] = '0;
    end
    pz_held = 1'b0; pz_held_for = '0;
    // A key held through reset must not count as a fresh press.
    mode_prev = 1'b1;
  endfunction

  function automatic logic [15:0] inc_sat16(logic [15:0] v);
    return v + {15'd0, ~&v};
  endfunction

  function automatic logic [9:0] inc_sat10(logic [9:0] v);
    return v + {9'd0, ~&v};
  endfunction

  // One second of time: the clock advances and the countdown, if it is shown
  // and running, steps down or flags that it has run out.
  function automatic void second_elapsed();
    if (!clk_paused) begin
      if (clk_sec != 6'd59) begin
        clk_sec = clk_sec + 6'd1;
      end else begin
        clk_sec = '0;
        if (clk_min != 6'd59) begin
          clk_min = clk_min + 6'd1;
        end else begin
          clk_min = '0;
          clk_hr  = (clk_hr == 5'd23) ? 5'd0 : clk_hr + 5'd1;
        end
      end
    end
    if (timer_mode && !tmr_paused) begin
      if (cd_hr == '0 && cd_min == '0 && cd_sec == '0) begin
        expired = 1'b1;
      end else begin
        expired = 1'b0;
        if (cd_sec != '0) begin
          cd_sec = cd_sec - 6'd1;
        end else begin
          cd_sec = 6'd59;
          if (cd_min != '0) begin
            cd_min = cd_min - 6'd1;
          end else begin
            cd_min = 6'd59;
            if (cd_hr != '0) cd_hr = cd_hr - 5'd1;
          end
        end
      end
    end
  endfunction

  // Add one to hours (0), minutes (1) or seconds (2) of the chosen time.
  function automatic void add_one(logic to_timer, int unsigned k);
    case (k)
      0: begin
        if (to_timer) cd_hr = (cd_hr == 5'd23) ? 5'd0 : cd_hr + 5'd1;
        else clk_hr = (clk_hr == 5'd23) ? 5'd0 : clk_hr + 5'd1;
      end
      1: begin
        if (to_timer) cd_min = (cd_min == 6'd59) ? 6'd0 : cd_min + 6'd1;
        else clk_min = (clk_min == 6'd59) ? 6'd0 : clk_min + 6'd1;
      end
      default: begin
        if (to_timer) cd_sec = (cd_sec == 6'd59) ? 6'd0 : cd_sec + 6'd1;
        else clk_sec = (clk_sec == 6'd59) ? 6'd0 : clk_sec + 6'd1;
      end
    endcase
  endfunction

  // Advance the model by one tick and return the display it leaves behind.
  function automatic out_item_t next_display(in_item_t t);
    logic        shown;
    logic        key [3];
    logic        lit;
    int unsigned h, mi, s;
    out_item_t   r;
    // Set keys and the pause key act on the mode shown before this tick.
    shown  = timer_mode;
    key[0] = t.hour_pressed;
    key[1] = t.minute_pressed;
    key[2] = t.second_pressed;

    sec_ticks = inc_sat10(sec_ticks);
    if (sec_ticks >= tps_cfg) begin
      sec_ticks = '0;
      second_elapsed();
    end

    // A set key adds one on a release before the long press time, and once
    // every repeat interval while it is held past that time.
    for (int k = 0; k < 3; k++) begin
      if (set_held[k]) begin
        set_held_for[k]  = inc_sat16(set_held_for[k]);
        set_since_rep[k] = inc_sat16(set_since_rep[k]);
      end
      if (key[k]) begin
        if (!set_held[k]) begin
          set_held[k] = 1'b1; set_held_for[k] = '0; set_since_rep[k] = '0;
        end else if (set_held_for[k] >= long_cfg && set_since_rep[k] >= repeat_cfg) begin
          add_one(shown, k);
          set_since_rep[k] = '0;
        end
      end else if (set_held[k]) begin
        if (set_held_for[k] < long_cfg) add_one(shown, k);
        set_held[k] = 1'b0;
      end
    end

    // The pause key toggles on a short release. A long hold clears and pauses
    // the shown time, then drops the hold so that a key still down starts over.
    if (pz_held) pz_held_for = inc_sat16(pz_held_for);
    if (t.pause_pressed) begin
      if (!pz_held) begin
        pz_held = 1'b1; pz_held_for = '0;
      end else if (pz_held_for >= zero_hold_cfg) begin
        if (shown) begin
          cd_hr = '0; cd_min = '0; cd_sec = '0; tmr_paused = 1'b1;
        end else begin
          clk_hr = '0; clk_min = '0; clk_sec = '0; clk_paused = 1'b1;
        end
        pz_held = 1'b0;
      end
    end else if (pz_held) begin
      if (pz_held_for < zero_hold_cfg) begin
        if (shown) tmr_paused = ~tmr_paused;
        else clk_paused = ~clk_paused;
      end
      pz_held = 1'b0;
    end

    if (!mode_prev && t.mode_pressed) timer_mode = ~timer_mode;
    mode_prev = t.mode_pressed;

    // The blink counter always runs; it only restarts when it flips the phase.
    blink_ticks = inc_sat10(blink_ticks);
    lit = 1'b1;
    if (timer_mode && expired) begin
      if (blink_ticks >= blink_cfg) begin
        blink_lit   = ~blink_lit;
        blink_ticks = '0;
      end
      lit = blink_lit;
    end

    h  = timer_mode ? cd_hr  : clk_hr;
    mi = timer_mode ? cd_min : clk_min;
    s  = timer_mode ? cd_sec : clk_sec;
    r.hours_tens    = 2'(h / 10);
    r.hours_units   = 4'(h % 10);
    r.minutes_tens  = 3'(mi / 10);
    r.minutes_units = 4'(mi % 10);
    r.seconds_tens  = 3'(s / 10);
    r.seconds_units = 4'(s % 10);
    r.display_on    = lit;
    r.in_timer_mode = timer_mode;
    r.clock_halted  = clk_paused;
    r.timer_halted  = tmr_paused;
    r.timer_expired = expired;
    return r;
  endfunction

  // Register writes land in the model as they land in the unit.
  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (cfg_idx_e'(idx))
      CfgLongPress: long_cfg      = val;
      CfgRepeat:    repeat_cfg    = val;
      CfgResetHold: zero_hold_cfg = val;
      CfgTicksSec:  tps_cfg       = val[9:0];
      CfgBlinkHalf: blink_cfg     = val[9:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offer one tick after a random gap and hold it until the unit takes it.
  task automatic send_tick(in_item_t t);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    pending_display.push_back(next_display(t));
    ticks_sent++;
  endtask

  task automatic hold_keys(in_item_t t, int unsigned n);
    repeat (n) send_tick(t);
  endtask

  // Stop offering ticks and let every queued display come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_display.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  // Write all five registers while the unit is idle. The 10-bit registers get
  // random junk in the upper data bits, which the unit must drop.
  task automatic configure(int unsigned lp, int unsigned rep, int unsigned rh,
                           int unsigned tps, int unsigned bh);
    wait_idle();
    write_reg(CfgLongPress, 16'(lp));
    write_reg(CfgRepeat,    16'(rep));
    write_reg(CfgResetHold, 16'(rh));
    write_reg(CfgTicksSec,  {6'($urandom), 10'(tps)});
    write_reg(CfgBlinkHalf, {6'($urandom), 10'(bh)});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic small_settings();
    configure($urandom_range(1, 12), $urandom_range(1, 4), $urandom_range(2, 30),
              $urandom_range(1, 8), $urandom_range(1, 6));
  endtask

  // Random key gestures: mostly one key pressed for a length that is drawn
  // around the hold times now in force, then released, with some noise ticks.
  task automatic random_gestures(int unsigned n);
    int unsigned goal, pick, k, dur;
    int          span;
    in_item_t    t;
    goal = ticks_sent + n;
    while (ticks_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        t   = in_item_t'(5'($urandom_range(0, 31)));
        dur = 1;
      end else begin
        k = $urandom_range(0, 4);
        t = in_item_t'(5'b10000 >> k);
        if ($urandom_range(0, 4) == 0) begin
          t = in_item_t'(t | (5'b10000 >> $urandom_range(0, 4)));
        end
        if (k < 3) span = int'(long_cfg) + 4 * int'(repeat_cfg) + 2;
        else if (k == 3) span = int'(zero_hold_cfg) + 4;
        else span = 3;
        if (span > 80) span = 80;
        dur = $urandom_range(1, span);
      end
      hold_keys(t, dur);
      if (pick >= 2) hold_keys(KeyNone, $urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Default registers. The mode key held through reset must not switch mode;
  // a fresh press does. A short second press then sets the countdown.
  task automatic test_after_reset();
    hold_keys(KeyMode, 2);
    hold_keys(KeyNone, 1);
    hold_keys(KeyMode, 1);
    hold_keys(KeyNone, 1);
    hold_keys(KeySecond, 1);
    hold_keys(KeyNone, 1);
  endtask

  // Every register at its lowest value: one tick per second, blink on every
  // tick, repeats on every tick, and a pause hold that clears at once.
  task automatic test_lowest_settings();
    configure(1, 1, 1, 1, 1);
    // The countdown reaches zero, expires and starts to blink.
    hold_keys(KeyNone, 3);
    hold_keys(KeyHour, 4);
    hold_keys(KeyNone, 1);
    hold_keys(KeyMinute, 1);
    hold_keys(KeyNone, 1);
    hold_keys(KeyPause, 1);
    hold_keys(KeyNone, 1);
    // A held pause key clears the timer, then starts a new hold.
    hold_keys(KeyPause, 3);
    hold_keys(KeyNone, 1);
    hold_keys(KeyMode, 1);
    hold_keys(KeyNone, 1);
    hold_keys(KeySecond, 3);
    hold_keys(KeyNone, 1);
  endtask

  // Registers written as zero act on every tick. A write to an index past the
  // last register must leave everything as it was.
  task automatic test_zero_settings();
    configure(0, 0, 0, 0, 0);
    @(posedge clk_i);
    write_reg(CfgUnused, 16'($urandom));
    cfg_we_i <= 1'b0;
    hold_keys(KeyHour, 3);
    hold_keys(KeyNone, 1);
    hold_keys(KeyPause, 2);
    hold_keys(KeyNone, 1);
    hold_keys(KeyMode, 1);
    hold_keys(KeyNone, 2);
    hold_keys(KeyPause, 1);
    hold_keys(KeyNone, 1);
  endtask

  // Every register at its highest value except the repeat interval. Presses
  // stay far below the long press and clear times, so each one is short.
  task automatic test_highest_settings();
    configure(65535, 1, 65535, 1023, 1023);
    hold_keys(KeySecond, 2);
    hold_keys(KeyNone, 1);
    hold_keys(KeyHour, 40);
    hold_keys(KeyNone, 1);
    hold_keys(KeyPause, 30);
    hold_keys(KeyNone, 1);
    hold_keys(KeyMode, 1);
    hold_keys(KeyNone, 1);
  endtask

  // Random gestures under several register settings, one stretch of them
  // with no gaps and no stalls at all.
  task automatic test_random_settings();
    small_settings();
    random_gestures(210);
    small_settings();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_gestures(210);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    configure($urandom_range(20, 50), $urandom_range(3, 10), $urandom_range(40, 70),
              $urandom_range(20, 60), $urandom_range(10, 40));
    random_gestures(210);
    small_settings();
    random_gestures(210);
  endtask

  // The receiver holds off long enough for the unit to fill and stall the
  // tick channel; later the sender stops until every display has come out.
  task automatic test_backpressure();
    small_settings();
    random_gestures(120);
    rx_hold_request = 60;
    random_gestures(60);
    wait_idle();
    random_gestures(90);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls a random number of cycles before each display transfer.
  // ---------------------------------------------------------------------------
  initial begin : drive_stall
    int unsigned n;
    forever begin
      if (rx_hold_request > 0) begin
        n = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        n = stalls_on ? $urandom_range(0, 6) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each display transfer against the oldest queued display.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_display
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      displays_seen++;
      if (pending_display.size() == 0) begin
        $error("display transfer with no tick waiting for it");
        fail_count++;
      end else begin
        want = pending_display.pop_front();
        check_field("hours_tens",    want.hours_tens,    out_data_o.hours_tens);
        check_field("hours_units",   want.hours_units,   out_data_o.hours_units);
        check_field("minutes_tens",  want.minutes_tens,  out_data_o.minutes_tens);
        check_field("minutes_units", want.minutes_units, out_data_o.minutes_units);
        check_field("seconds_tens",  want.seconds_tens,  out_data_o.seconds_tens);
        check_field("seconds_units", want.seconds_units, out_data_o.seconds_units);
        check_field("display_on",    want.display_on,    out_data_o.display_on);
        check_field("in_timer_mode", want.in_timer_mode, out_data_o.in_timer_mode);
        check_field("clock_halted",  want.clock_halted,  out_data_o.clock_halted);
        check_field("timer_halted",  want.timer_halted,  out_data_o.timer_halted);
        check_field("timer_expired", want.timer_expired, out_data_o.timer_expired);
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_lowest_settings();
    test_zero_settings();
    test_highest_settings();
    test_random_settings();
    test_backpressure();

    // Drain, then give the unit a few more cycles to show any stray display.
    wait_idle();
    repeat (5) @(posedge clk_i);
    if (pending_display.size() != 0) begin
      $error("%0d displays never came out", pending_display.size());
      fail_count++;
    end

    $display("Run covered %0d ticks and %0d checked displays under %0d register settings.",
             ticks_sent, displays_seen, settings_used);
    $display("It took in set-key repeats, pause toggles and clears, countdown expiry, %s",
             "blinking and the extreme register settings.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
